[hw/rtl/ffha_pkg.sv]
// Shared constants, item types and controller/datapath interface types of the heap allocator.
package ffha_pkg;

	localparam int HEADER_BYTES = 24;
	localparam int ALIGN_BYTES  = 16;
	localparam int INIT_PAGES   = 16;
	localparam int GROW_PAGES   = 4;
	localparam int MAX_PAGES    = 64;
	localparam int MAX_BLOCKS   = 64;
	localparam int PAGE_BYTES   = 4096;

	localparam int GROW_BYTES = GROW_PAGES * PAGE_BYTES;
	localparam int INIT_BYTES = INIT_PAGES * PAGE_BYTES;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SIZE_W = 18;
	localparam int SUM_W  = 19;
	localparam int OFF_W  = 20;
	localparam int WANT_W = 20;
	localparam int PG_W   = 7;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_IGNORED     = 3'd1,
		ST_OOM         = 3'd2,
		ST_DOUBLE_FREE = 3'd3,
		ST_NOT_BLOCK   = 3'd4
	} status_t;

	typedef struct packed {
		logic        command;
		logic [18:0] request_bytes;
		logic [17:0] release_offset;
	} request_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [17:0] payload_offset;
		logic [18:0] used_total;
		logic [18:0] free_total;
		logic [6:0]  region_pages;
	} result_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              free;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_INIT,
		OP_READ_I,
		OP_STEP,
		OP_TAKE_PREP,
		OP_TAKE_WHOLE,
		OP_READ_JM1,
		OP_WRITE_J_DEC,
		OP_SPLIT_HI,
		OP_SPLIT_LO,
		OP_GROW,
		OP_MARK_FREE,
		OP_LATCH_CUR,
		OP_READ_NEXT,
		OP_MERGE,
		OP_ADVANCE,
		OP_READ_JP1,
		OP_WRITE_J_INC,
		OP_DEC_CNT,
		OP_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;       // null free or zero-size allocate
		logic is_free;    // command is a free
		logic fits;       // current entry is free and large enough
		logic split_ok;   // leftover can hold a header plus one alignment unit
		logic last;       // current entry is the last one
		logic grow_ok;    // region can grow by one step
		logic hit;        // current entry payload offset equals the release offset
		logic rd_free;    // current entry is free
		logic shift_more; // right shift still has entries to move
		logic more;       // merge pass has a next entry
		logic both_free;  // merge candidate pair is free
		logic sl_more;    // left shift still has entries to move
	} dp_stat_t;

endpackage

[hw/rtl/ffha_ctrl.sv]
// Controller state machine that sequences table walks, shifts, growth and merging.
module ffha_ctrl import ffha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH,
		S_A_RD, S_A_EX, S_A_RESTART, S_T_CHK, S_T_SHWR, S_T_LO,
		S_F_RD, S_F_EX,
		S_M_INIT, S_M_RD0, S_M_CUR, S_M_CHK, S_M_EX, S_S_CHK, S_S_WR,
		S_FIN
	} state_t;

	state_t  state_q, state_d;
	status_t stat_q, stat_d;

	always_comb begin
		state_d    = state_q;
		stat_d     = stat_q;
		cmd.op     = OP_NONE;
		cmd.status = stat_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.zero) begin
					stat_d  = ST_IGNORED;
					state_d = S_FIN;
				end else if (stat.is_free) begin
					state_d = S_F_RD;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_RD: begin
				cmd.op  = OP_READ_I;
				state_d = S_A_EX;
			end
			S_A_EX: begin
				if (stat.fits) begin
					if (stat.split_ok) begin
						cmd.op  = OP_TAKE_PREP;
						state_d = S_T_CHK;
					end else begin
						cmd.op  = OP_TAKE_WHOLE;
						stat_d  = ST_OK;
						state_d = S_FIN;
					end
				end else if (stat.last) begin
					if (stat.grow_ok) begin
						cmd.op  = OP_GROW;
						state_d = S_A_RESTART;
					end else begin
						stat_d  = ST_OOM;
						state_d = S_FIN;
					end
				end else begin
					cmd.op  = OP_STEP;
					state_d = S_A_RD;
				end
			end
			S_A_RESTART: begin
				cmd.op  = OP_SCAN_INIT;
				state_d = S_A_RD;
			end
			S_T_CHK: begin
				if (stat.shift_more) begin
					cmd.op  = OP_READ_JM1;
					state_d = S_T_SHWR;
				end else begin
					cmd.op  = OP_SPLIT_HI;
					state_d = S_T_LO;
				end
			end
			S_T_SHWR: begin
				cmd.op  = OP_WRITE_J_DEC;
				state_d = S_T_CHK;
			end
			S_T_LO: begin
				cmd.op  = OP_SPLIT_LO;
				stat_d  = ST_OK;
				state_d = S_FIN;
			end
			S_F_RD: begin
				cmd.op  = OP_READ_I;
				state_d = S_F_EX;
			end
			S_F_EX: begin
				if (stat.hit) begin
					if (stat.rd_free) begin
						stat_d  = ST_DOUBLE_FREE;
						state_d = S_FIN;
					end else begin
						cmd.op  = OP_MARK_FREE;
						state_d = S_M_INIT;
					end
				end else if (stat.last) begin
					stat_d  = ST_NOT_BLOCK;
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_STEP;
					state_d = S_F_RD;
				end
			end
			S_M_INIT: begin
				cmd.op  = OP_SCAN_INIT;
				state_d = S_M_RD0;
			end
			S_M_RD0: begin
				cmd.op  = OP_READ_I;
				state_d = S_M_CUR;
			end
			S_M_CUR: begin
				cmd.op  = OP_LATCH_CUR;
				state_d = S_M_CHK;
			end
			S_M_CHK: begin
				if (stat.more) begin
					cmd.op  = OP_READ_NEXT;
					state_d = S_M_EX;
				end else begin
					stat_d  = ST_OK;
					state_d = S_FIN;
				end
			end
			S_M_EX: begin
				if (stat.both_free) begin
					cmd.op  = OP_MERGE;
					state_d = S_S_CHK;
				end else begin
					cmd.op  = OP_ADVANCE;
					state_d = S_M_CHK;
				end
			end
			S_S_CHK: begin
				if (stat.sl_more) begin
					cmd.op  = OP_READ_JP1;
					state_d = S_S_WR;
				end else begin
					cmd.op  = OP_DEC_CNT;
					state_d = S_M_CHK;
				end
			end
			S_S_WR: begin
				cmd.op  = OP_WRITE_J_INC;
				state_d = S_S_CHK;
			end
			S_FIN: begin
				cmd.op  = OP_DONE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> state_q == S_IDLE)
		else $error("finish state did not return to idle");
`endif

endmodule

[hw/rtl/ffha_datapath.sv]
// Datapath with the block table memory, walk registers, running totals and result register.
module ffha_datapath import ffha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  request_t request,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     result_valid,
	output result_t  result
);

	localparam entry_t INIT_ENTRY = '{size: SIZE_W'(INIT_BYTES - HEADER_BYTES), free: 1'b1};

	entry_t blk_mem [MAX_BLOCKS];
	entry_t rd_q;
	logic   init_sel_q;
	logic   v0_q;

	logic              cmd_q, zero_q;
	logic [WANT_W-1:0] want_q;
	logic [17:0]       target_q;
	logic [IDX_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OFF_W-1:0]  off_q;
	logic [PG_W-1:0]   pages_q;
	logic [SUM_W-1:0]  used_q, free_q;
	logic [17:0]       payload_q;
	logic [SIZE_W-1:0] sz_q;
	entry_t            cur_q;
	result_t           res_q;
	logic              res_v_q;

	entry_t            rd;
	logic              rd_en, wr_en;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	entry_t            wr_data;
	logic [CNT_W-1:0]  i_ext;
	logic [SIZE_W-1:0] merged;
	logic [WANT_W-1:0] want_d;

	assign rd     = init_sel_q ? INIT_ENTRY : rd_q;
	assign i_ext  = CNT_W'(i_q);
	assign merged = cur_q.size + SIZE_W'(HEADER_BYTES) + rd.size;
	assign want_d = (WANT_W'(request.request_bytes) + WANT_W'(ALIGN_BYTES - 1))
		& ~WANT_W'(ALIGN_BYTES - 1);

	// Status toward the controller.
	always_comb begin
		stat.zero       = zero_q;
		stat.is_free    = cmd_q;
		stat.fits       = rd.free && (WANT_W'(rd.size) >= want_q);
		stat.split_ok   = ((WANT_W + 1)'(rd.size)
			>= (WANT_W + 1)'(want_q) + (WANT_W + 1)'(HEADER_BYTES + ALIGN_BYTES))
			&& (cnt_q < CNT_W'(MAX_BLOCKS));
		stat.last       = (i_ext + CNT_W'(1)) == cnt_q;
		stat.grow_ok    = ((PG_W + 1)'(pages_q) + (PG_W + 1)'(GROW_PAGES)
			<= (PG_W + 1)'(MAX_PAGES)) && (rd.free || cnt_q < CNT_W'(MAX_BLOCKS));
		stat.hit        = (off_q + OFF_W'(HEADER_BYTES)) == OFF_W'(target_q);
		stat.rd_free    = rd.free;
		stat.shift_more = j_q > (i_ext + CNT_W'(1));
		stat.more       = (i_ext + CNT_W'(1)) < cnt_q;
		stat.both_free  = cur_q.free && rd.free;
		stat.sl_more    = (j_q + CNT_W'(1)) < cnt_q;
	end

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q;
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = rd;
		unique case (cmd.op)
			OP_READ_I: rd_en = 1'b1;
			OP_READ_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = i_q + IDX_W'(1);
			end
			OP_READ_JM1: begin
				rd_en   = 1'b1;
				rd_addr = j_q[IDX_W-1:0] - IDX_W'(1);
			end
			OP_READ_JP1: begin
				rd_en   = 1'b1;
				rd_addr = j_q[IDX_W-1:0] + IDX_W'(1);
			end
			OP_WRITE_J_DEC, OP_WRITE_J_INC: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IDX_W-1:0];
			end
			OP_TAKE_WHOLE: begin
				wr_en   = 1'b1;
				wr_data = '{size: rd.size, free: 1'b0};
			end
			OP_SPLIT_HI: begin
				wr_en   = 1'b1;
				wr_addr = i_q + IDX_W'(1);
				wr_data = '{size: sz_q - SIZE_W'(want_q) - SIZE_W'(HEADER_BYTES), free: 1'b1};
			end
			OP_SPLIT_LO: begin
				wr_en   = 1'b1;
				wr_data = '{size: SIZE_W'(want_q), free: 1'b0};
			end
			OP_GROW: begin
				wr_en = 1'b1;
				if (rd.free) begin
					wr_addr = cnt_q[IDX_W-1:0] - IDX_W'(1);
					wr_data = '{size: rd.size + SIZE_W'(GROW_BYTES), free: 1'b1};
				end else begin
					wr_addr = cnt_q[IDX_W-1:0];
					wr_data = '{size: SIZE_W'(GROW_BYTES - HEADER_BYTES), free: 1'b1};
				end
			end
			OP_MARK_FREE: begin
				wr_en   = 1'b1;
				wr_data = '{size: rd.size, free: 1'b1};
			end
			OP_MERGE: begin
				wr_en   = 1'b1;
				wr_data = '{size: merged, free: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= blk_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q       <= 1'b0;
			init_sel_q <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0) begin
				v0_q <= 1'b1;
			end
			if (rd_en) begin
				init_sel_q <= (rd_addr == '0) && !v0_q;
			end
		end
	end

	// Walk registers and running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= 1'b0;
			zero_q    <= 1'b0;
			want_q    <= '0;
			target_q  <= '0;
			i_q       <= '0;
			j_q       <= '0;
			off_q     <= '0;
			payload_q <= '0;
			sz_q      <= '0;
			cur_q     <= '0;
			res_q     <= '0;
			cnt_q     <= CNT_W'(1);
			pages_q   <= PG_W'(INIT_PAGES);
			used_q    <= '0;
			free_q    <= SUM_W'(INIT_BYTES - HEADER_BYTES);
			res_v_q   <= 1'b0;
		end else begin
			res_v_q <= (cmd.op == OP_DONE);
			unique case (cmd.op)
				OP_LOAD: begin
					cmd_q     <= request.command;
					want_q    <= want_d;
					target_q  <= request.release_offset;
					zero_q    <= request.command ? (request.release_offset == '0)
						: (request.request_bytes == '0);
					i_q       <= '0;
					off_q     <= '0;
					payload_q <= '0;
				end
				OP_SCAN_INIT: begin
					i_q   <= '0;
					off_q <= '0;
				end
				OP_STEP: begin
					off_q <= off_q + OFF_W'(HEADER_BYTES) + OFF_W'(rd.size);
					i_q   <= i_q + IDX_W'(1);
				end
				OP_TAKE_PREP: begin
					sz_q <= rd.size;
					j_q  <= cnt_q;
				end
				OP_TAKE_WHOLE: begin
					used_q    <= used_q + SUM_W'(HEADER_BYTES) + SUM_W'(rd.size);
					free_q    <= free_q - SUM_W'(rd.size);
					payload_q <= 18'(off_q + OFF_W'(HEADER_BYTES));
				end
				OP_WRITE_J_DEC: j_q <= j_q - CNT_W'(1);
				OP_SPLIT_LO: begin
					cnt_q     <= cnt_q + CNT_W'(1);
					used_q    <= used_q + SUM_W'(HEADER_BYTES) + SUM_W'(want_q);
					free_q    <= free_q - SUM_W'(want_q) - SUM_W'(HEADER_BYTES);
					payload_q <= 18'(off_q + OFF_W'(HEADER_BYTES));
				end
				OP_GROW: begin
					pages_q <= pages_q + PG_W'(GROW_PAGES);
					if (rd.free) begin
						free_q <= free_q + SUM_W'(GROW_BYTES);
					end else begin
						free_q <= free_q + SUM_W'(GROW_BYTES - HEADER_BYTES);
						cnt_q  <= cnt_q + CNT_W'(1);
					end
				end
				OP_MARK_FREE: begin
					used_q <= used_q - SUM_W'(HEADER_BYTES) - SUM_W'(rd.size);
					free_q <= free_q + SUM_W'(rd.size);
				end
				OP_LATCH_CUR: cur_q <= rd;
				OP_MERGE: begin
					cur_q.size <= merged;
					free_q     <= free_q + SUM_W'(HEADER_BYTES);
					j_q        <= i_ext + CNT_W'(1);
				end
				OP_ADVANCE: begin
					cur_q <= rd;
					i_q   <= i_q + IDX_W'(1);
				end
				OP_WRITE_J_INC: j_q <= j_q + CNT_W'(1);
				OP_DEC_CNT: cnt_q <= cnt_q - CNT_W'(1);
				OP_DONE: begin
					res_q.status         <= cmd.status;
					res_q.payload_offset <= payload_q;
					res_q.used_total     <= used_q;
					res_q.free_total     <= free_q;
					res_q.region_pages   <= pages_q;
				end
				default: ;
			endcase
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CNT_W'(MAX_BLOCKS))
		else $error("block count out of range");
	a_pages_range: assert property (@(posedge clk) disable iff (!arst_n)
		pages_q >= PG_W'(INIT_PAGES) && pages_q <= PG_W'(MAX_PAGES))
		else $error("page count out of range");
`endif

endmodule

[hw/rtl/first_fit_heap_allocator_top.sv]
// Top level of the first-fit heap allocator: controller plus datapath.
// The allocator keeps an address-ordered table of up to MAX_BLOCKS blocks in a
// single-port-read, single-port-write memory and handles one item at a time.
// An item is taken at a rising edge where start is high and busy is low; its
// result is shown on result for exactly one cycle with result_valid high, and
// the receiver must take it then, since the block cannot be held off. Every
// table read is registered (address, then registered read data), and an item
// walks the table entries in order, plus a move of each entry shifted up when
// a split makes room, a full walk again after each growth step, and for a
// free a merge pass over the table with a move of the later entries after each
// merge. A zero-size allocate or null free finishes without a table walk. No
// clearing pass is needed after reset: entry zero reads as the initial free
// block until it is first written.
module first_fit_heap_allocator_top import ffha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  request_t request,
	output logic     busy,
	output logic     result_valid,
	output result_t  result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller steps through walk, shift, growth and merge sequences.
	ffha_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	// The datapath owns the table memory, running totals and result register.
	ffha_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request),
		.cmd         (cmd),
		.stat        (stat),
		.result_valid(result_valid),
		.result      (result)
	);

`ifndef NO_ASSERTIONS
	a_result_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("item finished without a result");
	a_result_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while an item is in progress");
`endif

endmodule
